@@ hw/rtl/ptq_pkg.sv @@
// shared types and constants of the priority task queue
`default_nettype none

package ptq_pkg;

    localparam int TASK_W   = 64;
    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 2;
    localparam int DEPTH_W  = 9;
    localparam int TOTAL_W  = 11;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 280;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptq_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module ptq_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/priority_task_queue.sv @@
// strict-priority task queue: one fifo ring per priority in a shared task ram
//
//  channel   | direction | tdata / data                                  | tuser
//  ----------+-----------+-----------------------------------------------+-----------
//  s_*       | in        | priority_req, handler, context_req            | command
//  m_*       | out       | assigned_id, out_handler, out_context,        | accepted
//            |           | out_id, out_priority, ring_depth, pending_total|
//  cfg_*     | in        | running                                       | -
//
// each command goes through transfer in, ring update with one task ram access
// (write for push, read for pop), then result load into the output register.
// the registered read of the task ram is why the result load is a state of its own.
// reset clears ring pointers and counts at once; ram contents need no clearing.
// a result held by a stalled m_tready blocks the next result load, not the transfer in.
`default_nettype none

module priority_task_queue #(
    parameter int NUM_PRIORITIES = 4,
    parameter int RING_SLOTS     = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] priority_req, [65:2] handler, [129:66] context_req, rest zero
    input  wire logic [ptq_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] command
    input  wire logic [ptq_pkg::CMD_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [63:0] assigned_id, [127:64] out_handler, [191:128] out_context,
    // [255:192] out_id, [257:256] out_priority, [266:258] ring_depth,
    // [277:267] pending_total, rest zero
    output logic      [ptq_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] accepted
    output logic      [0:0]                      m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    // [0] running
    input  wire logic [0:0]                      cfg_data
);

    import ptq_pkg::*;

    localparam int IW       = $clog2(RING_SLOTS);
    localparam int CNT_W    = $clog2(RING_SLOTS + 1);
    localparam int PW       = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int PEND_W   = $clog2(NUM_PRIORITIES * RING_SLOTS + 1);
    localparam int MEM_DEPTH = 1 << (PW + IW);
    localparam int ENTRY_W  = 3 * TASK_W;

    localparam logic [IW-1:0]    LAST_IDX = IW'(RING_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_SLOTS);

    state_t state_reg, state_next;

    cmd_t                cmd_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [TASK_W-1:0]   handler_reg;
    logic [TASK_W-1:0]   ctx_reg;

    logic [IW-1:0]       head_reg  [NUM_PRIORITIES];
    logic [IW-1:0]       tail_reg  [NUM_PRIORITIES];
    logic [CNT_W-1:0]    count_reg [NUM_PRIORITIES];
    logic [PEND_W-1:0]   pend_reg;
    logic [TASK_W-1:0]   next_id_reg;
    logic                running_reg;

    logic [PW-1:0]       sel_reg;
    logic                push_ok_reg;
    logic                pop_ok_reg;
    logic [TASK_W-1:0]   assigned_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_acc_reg;

    // control from the state machine
    logic accept;
    logic exec;
    logic load;

    // ring selection and command decode
    logic                prio_in_range;
    logic [PW-1:0]       prio_idx;
    logic [PW-1:0]       pop_idx;
    logic                found;
    logic [PW-1:0]       sel;
    logic                id_take;
    logic                push_ok;
    logic                pop_ok;
    logic                is_flush;

    logic                ram_en;
    logic [PW+IW-1:0]    ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [DEPTH_W-1:0]  depth_val;
    logic [TASK_W-1:0]   res_handler;
    logic [TASK_W-1:0]   res_ctx;
    logic [TASK_W-1:0]   res_id;
    logic [PRIO_W-1:0]   res_prio;

    assign cfg_ready = 1'b1;

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        accept     = 1'b0;
        exec       = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    accept     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                exec       = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command decode and ring selection
    always_comb
    begin
        prio_in_range = (32'(prio_reg) < NUM_PRIORITIES);
        prio_idx      = PW'(prio_reg);
        pop_idx       = '0;
        found         = 1'b0;
        // lowest-numbered nonempty ring wins
        for (int p = NUM_PRIORITIES - 1; p >= 0; p--)
        begin
            if (count_reg[p] != '0)
            begin
                pop_idx = PW'(p);
                found   = 1'b1;
            end
        end
        sel      = (cmd_reg == CMD_POP) ? pop_idx : prio_idx;
        id_take  = (cmd_reg == CMD_PUSH) && running_reg && (handler_reg != '0);
        push_ok  = id_take && prio_in_range && (count_reg[sel] != FULL_CNT);
        pop_ok   = (cmd_reg == CMD_POP) && found;
        is_flush = (cmd_reg == CMD_FLUSH);
    end

    assign ram_en    = exec && (push_ok || pop_ok);
    assign ram_addr  = push_ok ? {sel, tail_reg[sel]} : {sel, head_reg[sel]};
    assign ram_wdata = {next_id_reg, ctx_reg, handler_reg};

    ptq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_task_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (push_ok),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // captured command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_t'(s_tuser);
            prio_reg    <= s_tdata[1:0];
            handler_reg <= s_tdata[65:2];
            ctx_reg     <= s_tdata[129:66];
        end
        if (exec)
        begin
            sel_reg      <= sel;
            push_ok_reg  <= push_ok;
            pop_ok_reg   <= pop_ok;
            assigned_reg <= push_ok ? next_id_reg : '0;
        end
    end

    // ring pointers, counts and id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PRIORITIES; p++)
            begin
                head_reg[p]  <= '0;
                tail_reg[p]  <= '0;
                count_reg[p] <= '0;
            end
            pend_reg    <= '0;
            next_id_reg <= TASK_W'(1);
            running_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                running_reg <= cfg_data[0];
            end
            if (exec)
            begin
                if (is_flush)
                begin
                    for (int p = 0; p < NUM_PRIORITIES; p++)
                    begin
                        head_reg[p]  <= '0;
                        tail_reg[p]  <= '0;
                        count_reg[p] <= '0;
                    end
                    pend_reg <= '0;
                end
                if (id_take)
                begin
                    // id zero is never handed out
                    next_id_reg <= (next_id_reg == '1) ? TASK_W'(1) : next_id_reg + 1'b1;
                end
                if (push_ok)
                begin
                    tail_reg[sel]  <= (tail_reg[sel] == LAST_IDX) ? '0 : tail_reg[sel] + 1'b1;
                    count_reg[sel] <= count_reg[sel] + 1'b1;
                    pend_reg       <= pend_reg + 1'b1;
                end
                if (pop_ok)
                begin
                    head_reg[sel]  <= (head_reg[sel] == LAST_IDX) ? '0 : head_reg[sel] + 1'b1;
                    count_reg[sel] <= count_reg[sel] - 1'b1;
                    if (pend_reg != '0)
                    begin
                        pend_reg <= pend_reg - 1'b1;
                    end
                end
            end
        end
    end

    // result assembly
    always_comb
    begin
        depth_val   = prio_in_range ? DEPTH_W'(count_reg[prio_idx]) : '0;
        res_handler = pop_ok_reg ? ram_rdata[TASK_W-1:0]          : '0;
        res_ctx     = pop_ok_reg ? ram_rdata[2*TASK_W-1:TASK_W]   : '0;
        res_id      = pop_ok_reg ? ram_rdata[3*TASK_W-1:2*TASK_W] : '0;
        res_prio    = pop_ok_reg ? PRIO_W'(sel_reg)               : '0;
    end

    assign out_valid_next = load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_acc_reg  <= push_ok_reg || pop_ok_reg;
            out_data_reg <= {2'b00, TOTAL_W'(pend_reg), depth_val, res_prio,
                             res_id, res_ctx, res_handler, assigned_reg};
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_acc_reg;

endmodule

`default_nettype wire
